@@ rtl/afb_pkg.sv @@
package afb_pkg;

    localparam int unsigned CFG_W     = 9;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd256;

    localparam logic [1:0] KIND_RECT  = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] span_w;
        logic signed [15:0] span_h;
        logic [31:0]        paint;
    } t_cmd;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        inside_res;
    } t_res;

    // Per-cycle memory operation issued by the walker.
    typedef struct packed {
        logic mem_rd;
        logic mem_wr;
        logic is_blend;
        logic is_read;
        logic in_canvas;
    } t_walk_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_BASE,
        S_WALK,
        S_READ
    } t_state;

endpackage

@@ rtl/alpha_blended_rect_fill.sv @@
// Alpha-blended rectangle fill over a 32-bit RGBA frame store held in one RAM.
// Commands are taken on i_cmd when start is high and busy is low. A rect command
// blends the paint color over the clipped rectangle, a clear command writes the
// paint to every pixel of the canvas in use, and a read command returns one pixel.
// Only reads produce a transaction on o_res, marked by o_strobe for one cycle; the
// receiver cannot hold it off.
// After acceptance the walker runs the clip step, then the row base multiply, then
// walks the covered pixels; a rect then drains through the blend pipeline. An
// empty rectangle ends after the clip step. A read passes through the setup, base
// and read states, r_p1_ctl and the strobe register; o_strobe rises at the same
// edge as busy falls. The one-pixel-per-cycle walk over the RAM sets the rate.
// The next command waits until the previous one has fully drained, which keeps a
// blend write from overlapping any later read of the same pixel.
// Canvas width and height are written through i_cfg_*; the user must write them
// only while busy is low, as the block does not enforce it. Both reset to 256 and
// are limited to MAX_COLS and MAX_ROWS. Reset idles the block; the frame store is
// not cleared and must be written by a clear before it is read.
module alpha_blended_rect_fill #(
    parameter int unsigned MAX_COLS = 256,
    parameter int unsigned MAX_ROWS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  afb_pkg::t_cmd                       i_cmd,
    output logic                                o_strobe,
    output afb_pkg::t_res                       o_res,
    input  logic                                i_cfg_we,
    input  logic [afb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [afb_pkg::CFG_W-1:0]           i_cfg_data
);
    import afb_pkg::*;

    localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CDW   = $clog2(MAX_COLS + 1);
    localparam int unsigned RDW   = $clog2(MAX_ROWS + 1);

    logic [CFG_W-1:0] r_cols;
    logic [CFG_W-1:0] r_rows;
    logic [CDW-1:0]   w_cols;
    logic [RDW-1:0]   w_rows;

    t_walk_ctl        w_ctl;
    logic [AW-1:0]    w_addr;
    logic [31:0]      w_paint;
    logic             w_walk_busy;
    logic             w_go;

    t_walk_ctl        r_p1_ctl;
    logic [AW-1:0]    r_p1_addr;
    logic [31:0]      r_p1_paint;

    logic [31:0]      w_rdata;
    logic             w_blend_wr;
    logic [AW-1:0]    w_blend_addr;
    logic [31:0]      w_blend_data;
    logic             w_blend_pend;

    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [31:0]      w_ram_wdata;

    logic             r_strobe;
    t_res             r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_DIM_RESET;
            r_rows <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end else if (i_cfg_idx == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end
        end
    end

    assign w_cols = (32'(r_cols) > 32'(MAX_COLS)) ? CDW'(MAX_COLS) : CDW'(r_cols);
    assign w_rows = (32'(r_rows) > 32'(MAX_ROWS)) ? RDW'(MAX_ROWS) : RDW'(r_rows);

    assign busy = w_walk_busy | r_p1_ctl.is_blend | r_p1_ctl.is_read | w_blend_pend;
    assign w_go = start & ~busy;

    afb_walk #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_cmd   (i_cmd),
        .i_cols  (w_cols),
        .i_rows  (w_rows),
        .o_ctl   (w_ctl),
        .o_addr  (w_addr),
        .o_paint (w_paint),
        .o_busy  (w_walk_busy)
    );

    // Clear writes come straight from the walker; blend writes follow their read via
    // r_p1_ctl and the blend stage register. A single command never produces both.
    assign w_ram_we    = w_ctl.mem_wr | w_blend_wr;
    assign w_ram_waddr = w_blend_wr ? w_blend_addr : w_addr;
    assign w_ram_wdata = w_blend_wr ? w_blend_data : w_paint;

    afb_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ctl.mem_rd),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_ctl <= '0;
        end else begin
            r_p1_ctl <= w_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr  <= w_addr;
        r_p1_paint <= w_paint;
    end

    afb_blend #(
        .AW (AW)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_p1_ctl.is_blend),
        .i_addr    (r_p1_addr),
        .i_paint   (r_p1_paint),
        .i_bg      (w_rdata),
        .o_wr_en   (w_blend_wr),
        .o_wr_addr (w_blend_addr),
        .o_wr_data (w_blend_data),
        .o_pend    (w_blend_pend)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_p1_ctl.is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.pixel_value <= r_p1_ctl.in_canvas ? w_rdata : '0;
        r_res.inside_res  <= r_p1_ctl.in_canvas;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_one_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_blend_wr && w_ctl.mem_wr))
        else $error("clear write and blend write collided");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (i_cmd.kind == KIND_RECT || i_cmd.kind == KIND_CLEAR ||
                  i_cmd.kind == KIND_READ)) |=> busy)
        else $error("accepted command did not raise busy");

    a_strobe_no_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !(w_blend_pend || r_p1_ctl.is_blend))
        else $error("read result overlapped a blend in flight");

endmodule

@@ rtl/afb_ram.sv @@
module afb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/afb_blend.sv @@
module afb_blend #(
    parameter int unsigned AW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_paint,
    input  logic [31:0]   i_bg,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [31:0]   o_wr_data,
    output logic          o_pend
);
    import afb_pkg::*;

    logic                 r_val;
    logic [AW-1:0]        r_addr;
    logic [2:0][7:0]      r_f;
    logic [2:0]           r_neg;
    logic [2:0][15:0]     r_prod;

    logic [7:0]           w_inv;
    logic [2:0][7:0]      n_f;
    logic [2:0]           n_neg;
    logic [2:0][15:0]     n_prod;
    logic [31:0]          w_data;

    assign w_inv = ALPHA_OPAQUE - i_paint[7:0];

    // Stage one: per-channel difference magnitude times inverse coverage.
    always_comb begin
        logic [7:0] fg;
        logic [7:0] bg;
        logic [7:0] mag;
        for (int c = 0; c < 3; c++) begin
            fg        = i_paint[8*(c+1) +: 8];
            bg        = i_bg[8*(c+1) +: 8];
            n_neg[c]  = bg < fg;
            mag       = n_neg[c] ? (fg - bg) : (bg - fg);
            n_f[c]    = fg;
            n_prod[c] = 16'(mag) * 16'(w_inv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= 1'b0;
        end else begin
            r_val <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= i_addr;
        r_f    <= n_f;
        r_neg  <= n_neg;
        r_prod <= n_prod;
    end

    // Stage two: divide by 255 with the add-and-shift identity, which is exact
    // for every product of two 8-bit values, then apply the signed offset and clamp.
    always_comb begin
        logic [16:0]       t;
        logic [7:0]        q;
        logic signed [9:0] s;
        w_data = '0;
        for (int c = 0; c < 3; c++) begin
            t = 17'(r_prod[c]) + 17'd1 + 17'(r_prod[c] >> 8);
            q = t[15:8];
            s = r_neg[c] ? (signed'(10'(r_f[c])) - signed'(10'(q)))
                         : (signed'(10'(r_f[c])) + signed'(10'(q)));
            if (s < 0) begin
                w_data[8*(c+1) +: 8] = 8'd0;
            end else if (s > 10'sd255) begin
                w_data[8*(c+1) +: 8] = 8'd255;
            end else begin
                w_data[8*(c+1) +: 8] = s[7:0];
            end
        end
    end

    assign o_wr_en   = r_val;
    assign o_wr_addr = r_addr;
    assign o_wr_data = w_data;
    assign o_pend    = r_val;

endmodule

@@ rtl/afb_walk.sv @@
module afb_walk #(
    parameter int unsigned MAX_COLS = 256,
    parameter int unsigned MAX_ROWS = 256,
    localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CDW   = $clog2(MAX_COLS + 1),
    localparam int unsigned RDW   = $clog2(MAX_ROWS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  afb_pkg::t_cmd       i_cmd,
    input  logic [CDW-1:0]      i_cols,
    input  logic [RDW-1:0]      i_rows,
    output afb_pkg::t_walk_ctl  o_ctl,
    output logic [AW-1:0]       o_addr,
    output logic [31:0]         o_paint,
    output logic                o_busy
);
    import afb_pkg::*;

    localparam int unsigned PW = CDW + RDW;

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [CDW-1:0]  r_px, n_px;
    logic [CDW-1:0]  r_x0, n_x0;
    logic [CDW-1:0]  r_x1, n_x1;
    logic [RDW-1:0]  r_py, n_py;
    logic [RDW-1:0]  r_y1, n_y1;
    logic [AW-1:0]   r_base, n_base;
    logic            r_inside, n_inside;

    logic [PW-1:0]      w_prod;
    logic signed [17:0] w_cols_s, w_rows_s;
    logic signed [17:0] w_x0, w_x1, w_y0, w_y1;
    logic signed [17:0] w_x0c, w_x1c, w_y0c, w_y1c;
    logic signed [17:0] w_px_s, w_py_s;

    assign w_prod   = PW'(r_py) * PW'(i_cols);
    assign w_cols_s = signed'(18'(i_cols));
    assign w_rows_s = signed'(18'(i_rows));
    assign w_px_s   = 18'(r_cmd.pos_x);
    assign w_py_s   = 18'(r_cmd.pos_y);

    // Normalize a signed span to a half-open interval, then clip it.
    always_comb begin
        if (r_cmd.kind == KIND_CLEAR) begin
            w_x0 = '0;
            w_x1 = w_cols_s;
            w_y0 = '0;
            w_y1 = w_rows_s;
        end else begin
            w_x0 = (r_cmd.span_w > 0) ? w_px_s : w_px_s + 18'(r_cmd.span_w);
            w_y0 = (r_cmd.span_h > 0) ? w_py_s : w_py_s + 18'(r_cmd.span_h);
            w_x1 = w_x0 + ((r_cmd.span_w < 0) ? -18'(r_cmd.span_w) : 18'(r_cmd.span_w));
            w_y1 = w_y0 + ((r_cmd.span_h < 0) ? -18'(r_cmd.span_h) : 18'(r_cmd.span_h));
        end
        w_x0c = (w_x0 < 0) ? '0 : w_x0;
        w_y0c = (w_y0 < 0) ? '0 : w_y0;
        w_x1c = (w_x1 > w_cols_s) ? w_cols_s : w_x1;
        w_y1c = (w_y1 > w_rows_s) ? w_rows_s : w_y1;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_px     = r_px;
        n_x0     = r_x0;
        n_x1     = r_x1;
        n_py     = r_py;
        n_y1     = r_y1;
        n_base   = r_base;
        n_inside = r_inside;
        o_ctl    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_cmd = i_cmd;
                    if (i_cmd.kind inside {KIND_RECT, KIND_CLEAR, KIND_READ}) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                if (r_cmd.kind == KIND_READ) begin
                    n_px     = CDW'(r_cmd.pos_x);
                    n_py     = RDW'(r_cmd.pos_y);
                    n_inside = (w_px_s >= 0) && (w_py_s >= 0) &&
                               (w_px_s < w_cols_s) && (w_py_s < w_rows_s);
                    n_state  = S_BASE;
                end else if ((w_x0c >= w_x1c) || (w_y0c >= w_y1c)) begin
                    n_state = S_IDLE;
                end else begin
                    n_x0    = CDW'(w_x0c);
                    n_px    = CDW'(w_x0c);
                    n_x1    = CDW'(w_x1c);
                    n_py    = RDW'(w_y0c);
                    n_y1    = RDW'(w_y1c);
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                n_base  = w_prod[AW-1:0];
                n_state = (r_cmd.kind == KIND_READ) ? S_READ : S_WALK;
            end
            S_READ: begin
                o_ctl.mem_rd    = r_inside;
                o_ctl.is_read   = 1'b1;
                o_ctl.in_canvas = r_inside;
                n_state         = S_IDLE;
            end
            S_WALK: begin
                if (r_cmd.kind == KIND_CLEAR) begin
                    o_ctl.mem_wr = 1'b1;
                end else begin
                    o_ctl.mem_rd   = 1'b1;
                    o_ctl.is_blend = 1'b1;
                end
                if ((r_px + CDW'(1)) == r_x1) begin
                    n_px = r_x0;
                    if ((r_py + RDW'(1)) == r_y1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_py   = r_py + RDW'(1);
                        n_base = r_base + AW'(i_cols);
                    end
                end else begin
                    n_px = r_px + CDW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_px     <= n_px;
        r_x0     <= n_x0;
        r_x1     <= n_x1;
        r_py     <= n_py;
        r_y1     <= n_y1;
        r_base   <= n_base;
        r_inside <= n_inside;
    end

    assign o_addr  = r_base + AW'(r_px);
    assign o_paint = r_cmd.paint;
    assign o_busy  = (r_state != S_IDLE);

    a_walk_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_px < r_x1) && (r_py < r_y1)))
        else $error("walker position left the clipped rectangle");

    a_read_after_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(r_state) == S_BASE))
        else $error("pixel read issued without a row base");

endmodule

@@ dv/tb_alpha_blended_rect_fill.sv @@
module tb_alpha_blended_rect_fill;
    import afb_pkg::*;

    localparam int MAX_COLS      = 256;
    localparam int MAX_ROWS      = 256;
    localparam int STALL_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int NUM_PHASES    = 11;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef struct {
        t_cmd cmd;
        bit   typed;
        t_res want;
    } t_stim_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_cmd                 i_cmd      = '0;
    logic                 o_strobe;
    t_res                 o_res;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Typed-in expectation that travels with the command being offered.
    bit   want_typed = 1'b0;
    t_res want_res   = '0;

    // Shadow of the frame store and the canvas registers.
    int        fb_cols = MAX_COLS;
    int        fb_rows = MAX_ROWS;
    bit [31:0] shadow_fb [MAX_COLS*MAX_ROWS];
    t_res      pending_reads [$];

    int mismatches  = 0;
    int idle_cycles = 0;

    alpha_blended_rect_fill #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic logic [31:0] blend_pixel(input logic [31:0] fg, input logic [31:0] bg);
        int          inv;
        int          ch;
        int          f;
        int          b;
        int          d;
        int          mag;
        int          o;
        logic [31:0] mix;
        inv = 255 - int'(fg[7:0]);
        mix = '0;
        for (ch = 1; ch < 4; ch++) begin
            f   = int'(fg[8*ch +: 8]);
            b   = int'(bg[8*ch +: 8]);
            d   = b - f;
            mag = ((d < 0) ? -d : d) * inv / 255;
            o   = (d < 0) ? f - mag : f + mag;
            if (o < 0) o = 0;
            if (o > 255) o = 255;
            mix[8*ch +: 8] = o[7:0];
        end
        return mix;
    endfunction

    task automatic apply_cmd(input t_cmd c, output bit has_res, output t_res res);
        int cols;
        int rows;
        int x;
        int y;
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        int px;
        int py;
        int i;
        cols    = (fb_cols > MAX_COLS) ? MAX_COLS : fb_cols;
        rows    = (fb_rows > MAX_ROWS) ? MAX_ROWS : fb_rows;
        x       = int'(c.pos_x);
        y       = int'(c.pos_y);
        w       = int'(c.span_w);
        h       = int'(c.span_h);
        has_res = 1'b0;
        res     = '0;
        case (c.kind)
            KIND_RECT: begin
                // Negative spans start at the far corner and run back to the origin.
                x0 = (w > 0) ? x : x + w;
                y0 = (h > 0) ? y : y + h;
                x1 = x0 + ((w < 0) ? -w : w);
                y1 = y0 + ((h < 0) ? -h : h);
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > cols) x1 = cols;
                if (y1 > rows) y1 = rows;
                for (py = y0; py < y1; py++) begin
                    for (px = x0; px < x1; px++) begin
                        shadow_fb[py*cols + px] = blend_pixel(c.paint, shadow_fb[py*cols + px]);
                    end
                end
            end
            KIND_CLEAR: begin
                for (i = 0; i < cols*rows; i++) shadow_fb[i] = c.paint;
            end
            KIND_READ: begin
                has_res = 1'b1;
                if (x >= 0 && y >= 0 && x < cols && y < rows) begin
                    res.pixel_value = shadow_fb[y*cols + x];
                    res.inside_res  = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Checks results, tracks accepted commands and register writes, and runs the watchdog.
    always @(posedge i_clk) begin
        t_res due;
        t_res pred;
        bit   has_res;
        if (!i_rst_n) begin
            fb_cols     = MAX_COLS;
            fb_rows     = MAX_ROWS;
            idle_cycles = 0;
        end else begin
            if (o_strobe) begin
                if (pending_reads.size() == 0) begin
                    flag_mismatch("result with no read pending", o_res.pixel_value, '0);
                end else begin
                    due = pending_reads.pop_front();
                    if (o_res.pixel_value !== due.pixel_value)
                        flag_mismatch("pixel_value", o_res.pixel_value, due.pixel_value);
                    if (o_res.inside_res !== due.inside_res)
                        flag_mismatch("inside_res", 32'(o_res.inside_res),
                                      32'(due.inside_res));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COLS) begin
                    fb_cols = int'(i_cfg_data);
                end else if (i_cfg_idx == CFG_ROWS) begin
                    fb_rows = int'(i_cfg_data);
                end
            end
            if (start && !busy) begin
                apply_cmd(i_cmd, has_res, pred);
                if (has_res) pending_reads.push_back(want_typed ? want_res : pred);
            end
            if ((start && !busy) || o_strobe || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic t_stim_row mk_row(input logic [1:0] kind, input int x, input int y,
                                         input int w, input int h, input logic [31:0] paint,
                                         input bit typed, input logic [31:0] pix,
                                         input logic ins);
        t_stim_row r;
        r.cmd.kind   = kind;
        r.cmd.pos_x  = x[15:0];
        r.cmd.pos_y  = y[15:0];
        r.cmd.span_w = w[15:0];
        r.cmd.span_h = h[15:0];
        r.cmd.paint  = paint;
        r.typed      = typed;
        r.want.pixel_value = pix;
        r.want.inside_res  = ins;
        return r;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic int pick_coord(input int lim, input bit for_read);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return int'($urandom_range(0, 65535)) - 32768;
        if (for_read && lim > 0 && r < 85) return $urandom_range(0, lim - 1);
        return int'($urandom_range(0, lim + 3)) - 2;
    endfunction

    function automatic int pick_span(input int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return int'($urandom_range(0, 65535)) - 32768;
        if (r < 25) return 0;
        return int'($urandom_range(0, 2*lim + 4)) - (lim + 2);
    endfunction

    function automatic t_cmd rand_cmd(input int lim_c, input int lim_r);
        t_cmd c;
        int   r;
        int   a;
        bit   is_read;
        r = $urandom_range(0, 99);
        a = $urandom_range(0, 99);
        if (r < 40) begin
            c.kind = KIND_READ;
        end else if (r < 80) begin
            c.kind = KIND_RECT;
        end else if (r < 92) begin
            c.kind = KIND_CLEAR;
        end else begin
            c.kind = KIND_UNUSED;
        end
        is_read  = (c.kind == KIND_READ);
        c.pos_x  = 16'(pick_coord(lim_c, is_read));
        c.pos_y  = 16'(pick_coord(lim_r, is_read));
        c.span_w = 16'(pick_span(lim_c));
        c.span_h = 16'(pick_span(lim_r));
        c.paint  = $urandom();
        if (a < 10) begin
            c.paint[7:0] = 8'h00;
        end else if (a < 20) begin
            c.paint[7:0] = ALPHA_OPAQUE;
        end
        return c;
    endfunction

    // Offers one command and returns right after the edge that accepts it.
    task automatic issue(input t_cmd c, input int gap, input bit typed, input t_res want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= c;
        want_typed <= typed;
        want_res   <= want;
        do @(posedge i_clk); while (!(start && !busy));
    endtask

    // Sampling at the falling edge sees busy raised by a command taken at the last edge.
    task automatic drain_wait();
        do @(negedge i_clk); while (pending_reads.size() != 0 || busy !== 1'b0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_canvas(input int cols, input int rows);
        start <= 1'b0;
        drain_wait();
        cfg_write(CFG_IDX_SPARE_A, CFG_W'($urandom()));
        cfg_write(CFG_COLS, cols[CFG_W-1:0]);
        cfg_write(CFG_ROWS, rows[CFG_W-1:0]);
        cfg_write(CFG_IDX_SPARE_B, CFG_W'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    // Every phase opens with a clear so that no pixel is read or blended before it is written.
    task automatic run_phase(input int cols, input int rows, input int n);
        int   lim_c;
        int   lim_r;
        int   k;
        bit   quiet;
        t_cmd c;
        set_canvas(cols, rows);
        lim_c   = (cols > MAX_COLS) ? MAX_COLS : cols;
        lim_r   = (rows > MAX_ROWS) ? MAX_ROWS : rows;
        quiet   = ($urandom_range(0, 3) == 0);
        c       = '0;
        c.kind  = KIND_CLEAR;
        c.paint = $urandom();
        issue(c, pick_gap(quiet), 1'b0, '0);
        for (k = 1; k < n; k++) issue(rand_cmd(lim_c, lim_r), pick_gap(quiet), 1'b0, '0);
    endtask

    initial begin
        t_stim_row rows [$];
        int        ph_cols  [NUM_PHASES];
        int        ph_rows  [NUM_PHASES];
        int        ph_items [NUM_PHASES];
        int        p;
        int        cols;
        int        nrows;

        // Outside reads need no stored pixel, so they may come before the first clear.
        rows.push_back(mk_row(KIND_READ, -1, 0, 0, 0, '0, 1, 32'h0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 0, -32768, 0, 0, '0, 1, 32'h0, 1'b0));
        rows.push_back(mk_row(KIND_CLEAR, 0, 0, 0, 0, 32'h11223344, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 0, 0, 0, 0, '0, 1, 32'h11223344, 1'b1));
        rows.push_back(mk_row(KIND_READ, 255, 255, 0, 0, '0, 1, 32'h11223344, 1'b1));
        rows.push_back(mk_row(KIND_READ, 256, 0, 0, 0, '0, 1, 32'h0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 32767, 32767, 0, 0, '0, 1, 32'h0, 1'b0));
        rows.push_back(mk_row(KIND_UNUSED, -32768, 32767, -1, -32768, 32'hFFFFFFFF,
                              0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 0, 255, 0, 0, '0, 1, 32'h11223344, 1'b1));
        // Opaque paint replaces the color and zeroes the alpha byte.
        rows.push_back(mk_row(KIND_RECT, 0, 0, 2, 2, 32'hAABBCCFF, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 1, 1, 0, 0, '0, 1, 32'hAABBCC00, 1'b1));
        // Fully transparent paint leaves the stored color as it was.
        rows.push_back(mk_row(KIND_RECT, 0, 0, 1, 1, 32'h12345600, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 0, 0, 0, 0, '0, 1, 32'hAABBCC00, 1'b1));
        rows.push_back(mk_row(KIND_RECT, 10, 10, -3, -2, 32'h80808080, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 7, 8, 0, 0, '0, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 6, 8, 0, 0, '0, 1, 32'h11223344, 1'b1));
        rows.push_back(mk_row(KIND_READ, 10, 10, 0, 0, '0, 1, 32'h11223344, 1'b1));
        rows.push_back(mk_row(KIND_RECT, 20, 20, 0, 5, 32'h000000FF, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 20, 20, 0, 0, '0, 1, 32'h11223344, 1'b1));
        rows.push_back(mk_row(KIND_RECT, 32767, 32767, -32768, -32768, 32'h7F0080C0,
                              0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 128, 200, 0, 0, '0, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_RECT, 250, 250, 100, 100, 32'hFF00FF40, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 255, 255, 0, 0, '0, 0, '0, 1'b0));
        rows.push_back(mk_row(KIND_RECT, -32768, -32768, 32767, 32767, 32'h01020304,
                              0, '0, 1'b0));
        rows.push_back(mk_row(KIND_READ, 0, 0, 0, 0, '0, 0, '0, 1'b0));

        // A negative width or height marks a canvas dimension that is drawn at random.
        ph_cols  = '{1, 256, 1, 511, 0, 9, 13, -1, -1, -1, 511};
        ph_rows  = '{1, 1, 256, 3, 7, 0, 11, -1, -1, -1, 511};
        ph_items = '{6, 8, 8, 8, 4, 3, 10, 7, 7, 7, 5};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) issue(rows[i].cmd, pick_gap(1'b0), rows[i].typed, rows[i].want);

        for (p = 0; p < NUM_PHASES; p++) begin
            cols  = (ph_cols[p] < 0) ? int'($urandom_range(2, 40)) : ph_cols[p];
            nrows = (ph_rows[p] < 0) ? int'($urandom_range(2, 40)) : ph_rows[p];
            run_phase(cols, nrows, ph_items[p]);
        end

        start <= 1'b0;
        drain_wait();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
